@@ rtl/scbrb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package scbrb_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned CountW = 7;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned DistW = 36;

  typedef enum logic [CfgIdxW-1:0] {
    RegBoxMinX = 3'd0,
    RegBoxMaxX = 3'd1,
    RegBoxMinY = 3'd2,
    RegBoxMaxY = 3'd3,
    RegBoxMinZ = 3'd4,
    RegBoxMaxZ = 3'd5,
    RegWanted  = 3'd6,
    RegDims    = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
    logic signed [CoordW-1:0] coord_z;
    logic                     last_point;
  } point_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic signed [CoordW-1:0] out_z;
    logic [CountW-1:0]        interior_total;
    logic                     exact_hit;
    logic [CoordW-1:0]        final_radius;
    logic                     last_result;
  } result_t;

  typedef enum logic [2:0] {
    StIdle,
    StSetup,
    StCount,
    StDecide,
    StEmit,
    StMarker
  } back_state_e;

endpackage
`default_nettype wire

@@ rtl/scbrb_stream_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface scbrb_stream_if #(
  parameter int unsigned Width = 1
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/scbrb_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Two-entry queue between point intake and the search engine.
module scbrb_front (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  scbrb_stream_if.sink   in_s,
  scbrb_stream_if.source q_s
);
  import scbrb_pkg::*;

  point_t     buf_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q, wr_q;
  logic       push, pop;

  assign in_s.ready = (cnt_q != 2'd2);
  assign push = in_s.valid && in_s.ready;
  assign q_s.valid = (cnt_q != 2'd0);
  assign q_s.data = buf_q[rd_q];
  assign pop = q_s.valid && q_s.ready;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    else if (pop && !push) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q <= 1'b0;
      wr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_q] <= in_s.data;
  end
endmodule
`default_nettype wire

@@ rtl/scbrb_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Point store, bisection search and result emission.
module scbrb_back #(
  parameter int unsigned MaxPoints = 64,
  parameter int unsigned MaxIterations = 100
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic [scbrb_pkg::CoordW-1:0] box_min_i [3],
  input  wire logic [scbrb_pkg::CoordW-1:0] box_max_i [3],
  input  wire logic [scbrb_pkg::CountW-1:0] wanted_i,
  input  wire logic [1:0] dims_i,
  scbrb_stream_if.sink   q_s,
  scbrb_stream_if.source out_s
);
  import scbrb_pkg::*;

  localparam int unsigned AddrW = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int unsigned LdW = $clog2(MaxPoints + 1);
  localparam int unsigned RndW = $clog2(MaxIterations + 1);

  logic [3*CoordW-1:0] mem [MaxPoints];
  logic [3*CoordW-1:0] rd_data_q;

  point_t q_pt;

  back_state_e st_q, st_d;
  logic [LdW-1:0]    loaded_q;
  logic [LdW-1:0]    idx_q, idx_d;   // read address issued
  logic              rvalid_q;       // rd_data_q holds entry idx_q-1
  logic [LdW-1:0]    ridx_q;
  logic [CoordW-1:0] lo_q, lo_d, hi_q, hi_d, rad_q, rad_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [CountW-1:0] sent_q, sent_d;
  logic [RndW-1:0]   rnd_q, rnd_d;
  logic [1:0]        nd_q;
  logic [2*CoordW+1:0] r2_q;
  logic              any_q, any_d;
  logic              exact_q, exact_d;

  // distance stage (combinational square sum of the registered point)
  logic signed [CoordW+1:0] dx, dy, dz;
  logic signed [DistW-1:0]  sqx, sqy, sqz;
  logic [DistW-1:0] dsum;
  logic             in_rad;

  // output register
  result_t res_q;
  logic    ovalid_q;
  logic    out_free;

  assign q_pt = q_s.data;

  assign out_free = !ovalid_q || out_s.ready;
  assign out_s.valid = ovalid_q;
  assign out_s.data = res_q;

  function automatic logic signed [CoordW+1:0] doff(input logic [CoordW-1:0] p,
      input logic [CoordW-1:0] mn, input logic [CoordW-1:0] mx);
    logic signed [CoordW+1:0] r;
    r = ({{1{p[CoordW-1]}}, p, 1'b0})
        - ({{2{mn[CoordW-1]}}, mn}) - ({{2{mx[CoordW-1]}}, mx});
    return r;
  endfunction

  function automatic logic [CoordW-1:0] hedge(input logic [CoordW-1:0] mn,
      input logic [CoordW-1:0] mx);
    logic signed [CoordW:0] e;
    e = $signed({mx[CoordW-1], mx}) - $signed({mn[CoordW-1], mn});
    return (e <= 0) ? '0 : e[CoordW:1];
  endfunction

  always_comb begin
    dx = doff(rd_data_q[3*CoordW-1:2*CoordW], box_min_i[0], box_max_i[0]);
    dy = doff(rd_data_q[2*CoordW-1:CoordW], box_min_i[1], box_max_i[1]);
    dz = doff(rd_data_q[CoordW-1:0], box_min_i[2], box_max_i[2]);
    sqx = dx * dx;
    sqy = dy * dy;
    sqz = dz * dz;
    dsum = unsigned'(sqx);
    if (nd_q >= 2'd2) dsum = dsum + unsigned'(sqy);
    if (nd_q == 2'd3) dsum = dsum + unsigned'(sqz);
    in_rad = dsum <= {r2_q, 2'b00};
  end

  logic [1:0] nd_eff;
  logic [CoordW-1:0] h0, h1, h2, hmin;
  logic [CoordW:0] msum;
  always_comb begin
    nd_eff = (dims_i == 2'd0) ? 2'd1 : dims_i;
    h0 = hedge(box_min_i[0], box_max_i[0]);
    h1 = hedge(box_min_i[1], box_max_i[1]);
    h2 = hedge(box_min_i[2], box_max_i[2]);
    hmin = h0;
    if (nd_eff >= 2'd2 && h1 < hmin) hmin = h1;
    if (nd_eff == 2'd3 && h2 < hmin) hmin = h2;
    msum = {1'b0, lo_q} + {1'b0, hi_q};
  end

  logic scan_done;
  assign scan_done = rvalid_q && (ridx_q + LdW'(1) == loaded_q);

  assign q_s.ready = (st_q == StIdle);

  always_comb begin
    st_d = st_q;
    idx_d = idx_q;
    lo_d = lo_q; hi_d = hi_q; rad_d = rad_q;
    cnt_d = cnt_q; rnd_d = rnd_q; any_d = any_q; exact_d = exact_q;
    sent_d = sent_q;
    case (st_q)
      StIdle: begin
        if (q_s.valid && q_pt.last_point) begin
          st_d = StSetup;
          rnd_d = '0;
        end
      end
      StSetup: begin
        lo_d = '0;
        hi_d = hmin;
        rnd_d = '0;
        rad_d = hmin >> 1;
        cnt_d = '0;
        idx_d = '0;
        st_d = (loaded_q == '0) ? StDecide : StCount;
      end
      StCount: begin
        if (idx_q != loaded_q) idx_d = idx_q + LdW'(1);
        if (rvalid_q && in_rad) cnt_d = cnt_q + CountW'(1);
        if (scan_done) st_d = StDecide;
      end
      StDecide: begin
        rnd_d = rnd_q + RndW'(1);
        exact_d = (cnt_q == wanted_i);
        if (cnt_q == wanted_i || rnd_q + RndW'(1) == RndW'(MaxIterations)) begin
          idx_d = '0;
          any_d = 1'b0;
          sent_d = '0;
          st_d = (loaded_q == '0) ? StMarker : StEmit;
        end else begin
          if (cnt_q > wanted_i) hi_d = rad_q;
          else lo_d = rad_q;
          st_d = StSetup;
        end
      end
      StEmit: begin
        if (out_free) begin
          if (idx_q != loaded_q) idx_d = idx_q + LdW'(1);
          if (rvalid_q && in_rad) begin
            any_d = 1'b1;
            sent_d = sent_q + CountW'(1);
          end
          if (scan_done) st_d = (any_q || in_rad) ? StIdle : StMarker;
        end
      end
      StMarker: begin
        if (out_free) st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
    // next radius for a further round comes from the updated bounds
    if (st_q == StSetup && rnd_q != '0) rad_d = msum[CoordW:1];
    if (st_q == StSetup && rnd_q != '0) begin
      lo_d = lo_q; hi_d = hi_q; rnd_d = rnd_q;
    end
  end

  // read enable: the pipeline advances while counting, and while emitting unless emission is stalled
  logic adv;
  always_comb begin
    adv = (st_q == StCount) || (st_q == StEmit && out_free);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      loaded_q <= '0;
      idx_q <= '0;
      rvalid_q <= 1'b0;
      ridx_q <= '0;
      lo_q <= '0; hi_q <= '0; rad_q <= '0;
      cnt_q <= '0; rnd_q <= '0;
      sent_q <= '0;
      nd_q <= 2'd3;
      r2_q <= '0;
      any_q <= 1'b0; exact_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      idx_q <= idx_d;
      lo_q <= lo_d; hi_q <= hi_d; rad_q <= rad_d;
      cnt_q <= cnt_d; rnd_q <= rnd_d;
      sent_q <= sent_d;
      any_q <= any_d; exact_q <= exact_d;
      if (st_q == StSetup) begin
        nd_q <= nd_eff;
        rvalid_q <= 1'b0;
      end else if (adv) begin
        rvalid_q <= (idx_q != loaded_q);
        ridx_q <= idx_q;
        if (scan_done) rvalid_q <= 1'b0;
      end else if (st_q == StDecide) begin
        rvalid_q <= 1'b0;
      end
      if (st_q == StSetup) r2_q <= (2*CoordW+2)'(rad_d * rad_d);
      if (st_q == StIdle && q_s.valid) begin
        if (loaded_q != LdW'(MaxPoints)) loaded_q <= loaded_q + LdW'(1);
      end
      if (st_q == StDecide && st_d != StSetup) loaded_q <= loaded_q;
      if ((st_q == StEmit || st_q == StMarker) && st_d == StIdle && out_free)
        loaded_q <= '0;
      if (out_free) ovalid_q <= 1'b0;
      if (st_q == StEmit && out_free && rvalid_q && in_rad) ovalid_q <= 1'b1;
      if (st_q == StMarker && out_free) ovalid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && q_s.valid && loaded_q != LdW'(MaxPoints))
      mem[loaded_q[AddrW-1:0]] <= {q_pt.coord_x, q_pt.coord_y, q_pt.coord_z};
    if (adv && idx_q != loaded_q) rd_data_q <= mem[idx_q[AddrW-1:0]];
    if (st_q == StEmit && out_free && rvalid_q && in_rad) begin
      res_q.out_x <= rd_data_q[3*CoordW-1:2*CoordW];
      res_q.out_y <= (nd_q >= 2'd2) ? rd_data_q[2*CoordW-1:CoordW] : '0;
      res_q.out_z <= (nd_q == 2'd3) ? rd_data_q[CoordW-1:0] : '0;
      res_q.interior_total <= cnt_q;
      res_q.exact_hit <= exact_q;
      res_q.final_radius <= rad_q;
      // last interior point of the run
      res_q.last_result <= (sent_q + CountW'(1) == cnt_q);
    end
    if (st_q == StMarker && out_free) begin
      res_q.out_x <= '0;
      res_q.out_y <= '0;
      res_q.out_z <= '0;
      res_q.interior_total <= '0;
      res_q.exact_hit <= exact_q;
      res_q.final_radius <= rad_q;
      res_q.last_result <= 1'b1;
    end
  end
endmodule
`default_nettype wire

@@ rtl/sphere_cut_by_radius_bisection_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Points load one per cycle into the point store through a two-entry queue, while the search is idle.
// After the last point, the search runs up to MaxIterations bisection rounds, with one
// memory read per point per round through a single read port.
// Emission then reads each point once more and stalls with the output; a marker follows if none is inside.
// Reset (asynchronous, active low) clears control state and restores register defaults.
module sphere_cut_by_radius_bisection_unit #(
  parameter int unsigned MaxPoints = 64,
  parameter int unsigned MaxIterations = 100
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [scbrb_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [scbrb_pkg::CfgDataW-1:0] cfg_data_i,
  scbrb_stream_if.sink   in_s,
  scbrb_stream_if.source out_s
);
  import scbrb_pkg::*;

  logic [CoordW-1:0] box_min_q [3];
  logic [CoordW-1:0] box_max_q [3];
  logic [CountW-1:0] wanted_q;
  logic [1:0]        dims_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        box_min_q[k] <= 16'h8000;
        box_max_q[k] <= 16'h7fff;
      end
      wanted_q <= 7'd32;
      dims_q <= 2'd3;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        RegBoxMinX: box_min_q[0] <= cfg_data_i;
        RegBoxMaxX: box_max_q[0] <= cfg_data_i;
        RegBoxMinY: box_min_q[1] <= cfg_data_i;
        RegBoxMaxY: box_max_q[1] <= cfg_data_i;
        RegBoxMinZ: box_min_q[2] <= cfg_data_i;
        RegBoxMaxZ: box_max_q[2] <= cfg_data_i;
        RegWanted:  wanted_q <= cfg_data_i[CountW-1:0];
        RegDims:    dims_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  scbrb_stream_if #(.Width($bits(point_t))) q_if ();

  scbrb_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_s(in_s), .q_s(q_if.source)
  );

  scbrb_back #(.MaxPoints(MaxPoints), .MaxIterations(MaxIterations)) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .box_min_i(box_min_q), .box_max_i(box_max_q),
    .wanted_i(wanted_q), .dims_i(dims_q),
    .q_s(q_if.sink), .out_s(out_s)
  );
endmodule
`default_nettype wire

@@ bench/scbrb_cut_checker.sv @@
`timescale 1ns / 1ps
module scbrb_cut_checker
  import scbrb_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  scbrb_stream_if        mon_in,
  scbrb_stream_if        mon_out,
  output int             fail_count_o,
  output int             pending_o
);

  localparam int StoreDepth = 64;
  localparam int RoundCap = 100;

  logic signed [CoordW-1:0] box_lo [3];
  logic signed [CoordW-1:0] box_hi [3];
  logic [CountW-1:0] want_cnt;
  logic [1:0]        dim_sel;

  int pts [StoreDepth][3];
  int n_loaded;
  result_t cut_q[$];
  int n_fail;

  assign fail_count_o = n_fail;

  function automatic bit in_sphere(int i, int unsigned r, int nd);
    longint sum;
    longint d;
    sum = 0;
    for (int k = 0; k < nd; k++) begin
      d = 2 * longint'(pts[i][k]) - (longint'(box_lo[k]) + longint'(box_hi[k]));
      sum += d * d;
    end
    return sum <= 4 * longint'(r) * longint'(r);
  endfunction

  // bisection on the radius, then queue the interior points in load order
  task automatic predict_cut();
    int nd;
    int unsigned r_lo, r_hi, r, h;
    int cnt, e, emitted;
    bit hit;
    result_t res;
    nd = (dim_sel == 0) ? 1 : dim_sel;
    r_lo = 0;
    r_hi = 16'hFFFF;
    r = 0;
    cnt = 0;
    for (int k = 0; k < nd; k++) begin
      e = int'(box_hi[k]) - int'(box_lo[k]);
      h = (e <= 0) ? 0 : (e >> 1);
      if (h < r_hi) r_hi = h;
    end
    for (int rnd = 0; rnd < RoundCap; rnd++) begin
      r = (r_lo + r_hi) >> 1;
      cnt = 0;
      for (int i = 0; i < n_loaded; i++) if (in_sphere(i, r, nd)) cnt++;
      if (cnt == want_cnt) break;
      if (cnt > want_cnt) r_hi = r;
      else r_lo = r;
    end
    hit = (cnt == want_cnt);
    emitted = 0;
    for (int i = 0; i < n_loaded; i++) begin
      if (in_sphere(i, r, nd)) begin
        res.out_x = 16'(pts[i][0]);
        res.out_y = (nd >= 2) ? 16'(pts[i][1]) : 16'd0;
        res.out_z = (nd >= 3) ? 16'(pts[i][2]) : 16'd0;
        res.interior_total = 7'(cnt);
        res.exact_hit = hit;
        res.final_radius = 16'(r);
        res.last_result = 1'b0;
        cut_q.push_back(res);
        emitted++;
      end
    end
    if (emitted == 0) begin
      res = '0;
      res.exact_hit = hit;
      res.final_radius = 16'(r);
      res.last_result = 1'b1;
      cut_q.push_back(res);
    end else begin
      cut_q[cut_q.size()-1].last_result = 1'b1;
    end
    n_loaded = 0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    point_t  pt;
    result_t got, exp_r;
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        box_lo[k] = 16'sh8000;
        box_hi[k] = 16'sh7FFF;
      end
      want_cnt = 7'd32;
      dim_sel = 2'd3;
      n_loaded = 0;
      n_fail = 0;
      cut_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          RegBoxMinX: box_lo[0] = cfg_data_i;
          RegBoxMaxX: box_hi[0] = cfg_data_i;
          RegBoxMinY: box_lo[1] = cfg_data_i;
          RegBoxMaxY: box_hi[1] = cfg_data_i;
          RegBoxMinZ: box_lo[2] = cfg_data_i;
          RegBoxMaxZ: box_hi[2] = cfg_data_i;
          RegWanted:  want_cnt = cfg_data_i[CountW-1:0];
          RegDims:    dim_sel = cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (mon_out.valid && mon_out.ready) begin
        got = mon_out.data;
        if (cut_q.size() == 0) begin
          $error("result transaction with nothing expected: %p", got);
          n_fail++;
        end else begin
          exp_r = cut_q.pop_front();
          if (got.out_x !== exp_r.out_x) begin
            $error("out_x exp %0d got %0d", exp_r.out_x, got.out_x); n_fail++;
          end
          if (got.out_y !== exp_r.out_y) begin
            $error("out_y exp %0d got %0d", exp_r.out_y, got.out_y); n_fail++;
          end
          if (got.out_z !== exp_r.out_z) begin
            $error("out_z exp %0d got %0d", exp_r.out_z, got.out_z); n_fail++;
          end
          if (got.interior_total !== exp_r.interior_total) begin
            $error("interior_total exp %0d got %0d", exp_r.interior_total,
                   got.interior_total); n_fail++;
          end
          if (got.exact_hit !== exp_r.exact_hit) begin
            $error("exact_hit exp %0b got %0b", exp_r.exact_hit, got.exact_hit); n_fail++;
          end
          if (got.final_radius !== exp_r.final_radius) begin
            $error("final_radius exp %0d got %0d", exp_r.final_radius,
                   got.final_radius); n_fail++;
          end
          if (got.last_result !== exp_r.last_result) begin
            $error("last_result exp %0b got %0b", exp_r.last_result,
                   got.last_result); n_fail++;
          end
        end
      end
      if (mon_in.valid && mon_in.ready) begin
        pt = mon_in.data;
        if (n_loaded < StoreDepth) begin
          pts[n_loaded][0] = pt.coord_x;
          pts[n_loaded][1] = pt.coord_y;
          pts[n_loaded][2] = pt.coord_z;
          n_loaded++;
        end
        if (pt.last_point) predict_cut();
      end
    end
    pending_o = cut_q.size();
  end

endmodule

@@ bench/tb_sphere_cut_by_radius_bisection_unit.sv @@
`timescale 1ns / 1ps
module tb_sphere_cut_by_radius_bisection_unit;
  import scbrb_pkg::*;

  localparam int WatchLimit = 100000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  int fail_count, pending;
  bit quiet;
  int idle_cycles;

  logic signed [CoordW-1:0] lo_c [3];
  logic signed [CoordW-1:0] hi_c [3];

  scbrb_stream_if #(.Width($bits(point_t)))  pt_if ();
  scbrb_stream_if #(.Width($bits(result_t))) res_if ();

  sphere_cut_by_radius_bisection_unit uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_s      (pt_if),
    .out_s     (res_if)
  );

  scbrb_cut_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .mon_in      (pt_if),
    .mon_out     (res_if),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // result side back-pressure
  always @(negedge clk_i) begin
    res_if.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 22);
  end

  always @(posedge clk_i) begin
    if ((pt_if.valid && pt_if.ready) || (res_if.valid && res_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WatchLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      RegBoxMinX: lo_c[0] = val;
      RegBoxMaxX: hi_c[0] = val;
      RegBoxMinY: lo_c[1] = val;
      RegBoxMaxY: hi_c[1] = val;
      RegBoxMinZ: lo_c[2] = val;
      RegBoxMaxZ: hi_c[2] = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_box(int k, logic [15:0] lo, logic [15:0] hi);
    write_reg(reg_idx_e'(2 * k), lo);
    write_reg(reg_idx_e'(2 * k + 1), hi);
  endtask

  // wait for the block to drain, plus a margin for the tail of the emission
  task automatic drain();
    pt_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  // valid stays up after acceptance; drain() takes it down, and the next call may do so while it waits
  task automatic send_point(logic [15:0] x, logic [15:0] y, logic [15:0] z, bit fin);
    point_t p;
    p.coord_x = x;
    p.coord_y = y;
    p.coord_z = z;
    p.last_point = fin;
    while (!quiet && $urandom_range(99) < 22) begin
      pt_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    pt_if.valid <= 1'b1;
    pt_if.data <= p;
    do @(posedge clk_i); while (!pt_if.ready);
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] near_coord(int k);
    int c, span, v;
    c = (int'(lo_c[k]) + int'(hi_c[k])) / 2;
    span = (int'(hi_c[k]) - int'(lo_c[k])) / 2;
    if (span < 4) span = 4;
    v = c + $signed($urandom_range(2 * span)) - span;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  // one point set; mostly points spread over the box, some anywhere
  task automatic run_set(int size, int wild_pct);
    for (int i = 0; i < size; i++) begin
      if ($urandom_range(99) < wild_pct)
        send_point(16'($urandom), 16'($urandom), 16'($urandom), i == size - 1);
      else
        send_point(near_coord(0), near_coord(1), near_coord(2), i == size - 1);
    end
  endtask

  initial begin
    int lo, hi, sz;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    pt_if.valid = 1'b0;
    pt_if.data = '0;
    res_if.ready = 1'b0;
    quiet = 1'b0;
    idle_cycles = 0;
    for (int k = 0; k < 3; k++) begin
      lo_c[k] = 16'sh8000;
      hi_c[k] = 16'sh7FFF;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset settings, coordinate extremes, centre point
    send_point(16'h8000, 16'h8000, 16'h8000, 1'b0);
    send_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
    send_point(16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_point(16'hFFFF, 16'h0001, 16'h8000, 1'b1);
    drain();
    // wanted zero, one dimension: likely marker
    write_reg(RegWanted, 16'd0);
    write_reg(RegDims, 16'd1);
    send_point(16'h4000, 16'h1234, 16'h5678, 1'b1);
    drain();
    // zero dimensions, inverted x edge, two points, both at the x centre
    write_reg(RegDims, 16'd0);
    set_box(0, 16'h1000, 16'hF000);
    write_reg(RegWanted, 16'd1);
    send_point(16'h0000, 16'h7FFF, 16'h8000, 1'b0);
    send_point(16'h0000, 16'h0001, 16'h0002, 1'b1);
    drain();
    // unreachable count: wanted above the set size
    set_box(0, 16'h8000, 16'h7FFF);
    write_reg(RegDims, 16'd2);
    write_reg(RegWanted, 16'd64);
    run_set(5, 50);
    drain();

    // store overflow: last two points dropped, search still runs
    write_reg(RegDims, 16'd3);
    write_reg(RegWanted, 16'd10);
    quiet = 1'b1;
    run_set(66, 20);
    drain();
    quiet = 1'b0;

    for (int ph = 0; ph < 10; ph++) begin
      write_reg(RegDims, (ph % 4 == 3) ? 16'd0 : 16'(ph % 3 + 1));
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(4))
          0: set_box(k, 16'h8000, 16'h7FFF);
          1: set_box(k, 16'h7FFF, 16'h8000);
          default: begin
            lo = $signed($urandom_range(65535)) - 32768;
            hi = lo + $urandom_range(20000);
            if (hi > 32767) hi = 32767;
            set_box(k, 16'(lo), 16'(hi));
          end
        endcase
      end
      write_reg(RegWanted, (ph == 5) ? 16'd64 : 16'($urandom_range(6)));
      quiet = (ph == 4);
      for (int s = 0; s < 5; s++) begin
        sz = ($urandom_range(19) == 0) ? 64 : $urandom_range(1, 8);
        run_set(sz, 10);
      end
      drain();
    end
    quiet = 1'b0;

    drain();
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ sphere_cut_by_radius_bisection_unit.f @@
rtl/scbrb_pkg.sv
rtl/scbrb_stream_if.sv
rtl/scbrb_front.sv
rtl/scbrb_back.sv
rtl/sphere_cut_by_radius_bisection_unit.sv
bench/scbrb_cut_checker.sv
bench/tb_sphere_cut_by_radius_bisection_unit.sv
